// ----- rtl/nibble_frame_reply_decoder_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef NIBBLE_FRAME_REPLY_DECODER_ASSERT_SVH
`define NIBBLE_FRAME_REPLY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define NFRD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfrd: same-cycle check failed");

// Next-cycle implication.
`define NFRD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfrd: next-cycle check failed");

// Invariant.
`define NFRD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("nfrd: invariant failed");

`else

`define NFRD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NFRD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`define NFRD_ASSERT_ALWAYS(lbl, clk, rst, cond)

`endif

`endif

// ----- rtl/nfrd_pkg.sv -----
package nfrd_pkg;

   localparam int NFRD_MAX_PAYLOAD = 8;

   // frame kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_ANALOG  = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FRAMING  = 3'd1;
   localparam logic [2:0] ST_DEVICE   = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_CAPACITY = 3'd4;
   localparam logic [2:0] ST_UNKNOWN  = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_ACK_CODE        = 3'd0;
   localparam logic [2:0] CSR_LENGTH_PREFIX   = 3'd1;
   localparam logic [2:0] CSR_CHECKSUM_PREFIX = 3'd2;
   localparam logic [2:0] CSR_DATA_PREFIX     = 3'd3;
   localparam logic [2:0] CSR_END_MARKER      = 3'd4;
   localparam logic [2:0] CSR_READ_CAPACITY   = 3'd5;

   // configuration reset values
   localparam logic [7:0] RST_ACK_CODE        = 8'hc0;
   localparam logic [3:0] RST_LENGTH_PREFIX   = 4'hb;
   localparam logic [3:0] RST_CHECKSUM_PREFIX = 4'h9;
   localparam logic [3:0] RST_DATA_PREFIX     = 4'h8;
   localparam logic [7:0] RST_END_MARKER      = 8'haf;
   localparam logic [3:0] RST_READ_CAPACITY   = 4'd8;

   // length byte codes
   localparam logic [7:0] LEN_SPECIAL     = 8'hbf;
   localparam logic [3:0] CMD_ACK_NIBBLE  = 4'hc;
   localparam logic [4:0] COV_SPECIAL_ACK = 5'd9;
   localparam logic [4:0] COV_SPECIAL     = 5'd5;
   localparam logic [4:0] COV_START       = 5'd4;

   // error flag bits
   localparam int FLAG_TAIL = 0;
   localparam int FLAG_DATA = 1;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data_byte;
      logic [3:0]  channel;
      logic [3:0]  signal_kind;
      logic [15:0] sample_value;
      logic        last;
   } result_type;

endpackage

// ----- rtl/nibble_frame_reply_decoder.sv -----
// Reply-frame decoder: takes one received byte per cycle unless stalled and
// keeps the frame state in registers, with register-read payload bytes
// written to a small payload memory (depth MAX_PAYLOAD_BYTES, registered
// read). At the end byte of a frame a single status result is queued at once;
// a register-read reply that passes every check instead reads its N payload
// bytes back from the memory, one per cycle while the result queue has room,
// followed by the status. The input is stalled while that runs, until the
// status is queued. The result side is a two-entry queue, so outside a
// read-back input bytes keep flowing while one result waits; the input then
// stalls only when both entries are full.
`include "nibble_frame_reply_decoder_assert.svh"

module nibble_frame_reply_decoder
   import nfrd_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = NFRD_MAX_PAYLOAD
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_channel,
   output logic [3:0]  rsp_signal_kind,
   output logic [15:0] rsp_sample_value,
   output logic        rsp_last,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
   localparam logic [3:0] MAX_CNT = 4'(MAX_PAYLOAD_BYTES);

   // configuration
   logic [7:0] ack_code_ff;
   logic [3:0] length_prefix_ff;
   logic [3:0] checksum_prefix_ff;
   logic [3:0] data_prefix_ff;
   logic [7:0] end_marker_ff;
   logic [3:0] read_capacity_ff;

   // frame state
   logic        open_ff,  open_in;
   logic [4:0]  pos_ff,   pos_in;
   logic [1:0]  kind_ff,  kind_in;
   logic [7:0]  xor_ff,   xor_in;
   logic [4:0]  cov_ff,   cov_in;
   logic [7:0]  cmd_ff,   cmd_in;
   logic [7:0]  src_ff,   src_in;
   logic [7:0]  len_ff,   len_in;
   logic [3:0]  hold_ff,  hold_in;
   logic [3:0]  pcnt_ff,  pcnt_in;
   logic [15:0] acc_ff,   acc_in;
   logic [3:0]  kindn_ff, kindn_in;
   logic [7:0]  rcs_ff,   rcs_in;
   logic [1:0]  eflags_ff, eflags_in;

   // payload memory
   logic [7:0]       payload_mem [MAX_PAYLOAD_BYTES];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [7:0]       mem_wdata;
   logic             store_req;
   logic [7:0]       store_data;

   // read-back sequencer
   logic       drain_busy_ff, drain_busy_in;
   logic [3:0] drain_idx_ff,  drain_idx_in;
   logic [3:0] drain_cnt_ff,  drain_cnt_in;
   logic       rd_pending_ff;
   logic [7:0] rd_data_ff;
   logic       rd_issue;
   logic [2:0] occ_after;

   // result queue
   result_type q_ff [2];
   logic       q_wr_ff, q_rd_ff;
   logic [1:0] q_count_ff, q_count_in;
   logic       push, pop;
   result_type push_res;
   logic       in_push;
   result_type in_res;
   logic       drain_status_push;

   // per-byte working values
   logic       req_fire;
   logic [4:0] p;
   logic [4:0] total;
   logic [4:0] tail_start;
   logic [4:0] off;
   logic [4:0] off_m1;
   logic [3:0] cap;
   logic       head_bad, tail_bad, cmd_bad, cov_bad, crc_bad, cap_bad;
   logic [2:0] st_sel;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = drain_busy_ff || (q_count_ff == 2'd2);
   assign csr_ready = 1'b1;
   assign cap       = (read_capacity_ff > MAX_CNT) ? MAX_CNT : read_capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff        <= RST_ACK_CODE;
         length_prefix_ff   <= RST_LENGTH_PREFIX;
         checksum_prefix_ff <= RST_CHECKSUM_PREFIX;
         data_prefix_ff     <= RST_DATA_PREFIX;
         end_marker_ff      <= RST_END_MARKER;
         read_capacity_ff   <= RST_READ_CAPACITY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACK_CODE:        ack_code_ff        <= csr_wdata;
            CSR_LENGTH_PREFIX:   length_prefix_ff   <= csr_wdata[3:0];
            CSR_CHECKSUM_PREFIX: checksum_prefix_ff <= csr_wdata[3:0];
            CSR_DATA_PREFIX:     data_prefix_ff     <= csr_wdata[3:0];
            CSR_END_MARKER:      end_marker_ff      <= csr_wdata;
            CSR_READ_CAPACITY:   read_capacity_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // byte processing
   always_comb begin
      open_in   = open_ff;
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      xor_in    = xor_ff;
      cov_in    = cov_ff;
      cmd_in    = cmd_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      hold_in   = hold_ff;
      pcnt_in   = pcnt_ff;
      acc_in    = acc_ff;
      kindn_in  = kindn_ff;
      rcs_in    = rcs_ff;
      eflags_in = eflags_ff;
      store_req  = 1'b0;
      store_data = '0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      in_push    = 1'b0;
      in_res     = '0;
      drain_busy_in = drain_busy_ff;
      drain_idx_in  = drain_idx_ff;
      drain_cnt_in  = drain_cnt_ff;
      p          = '0;
      total      = '0;
      tail_start = '0;
      off        = '0;
      off_m1     = '0;
      head_bad   = 1'b0;
      tail_bad   = 1'b0;
      cmd_bad    = 1'b0;
      cov_bad    = 1'b0;
      crc_bad    = 1'b0;
      cap_bad    = 1'b0;
      st_sel     = ST_OK;

      if (req_fire) begin
         if (req_frame_start && (req_operation == KIND_UNKNOWN)) begin
            kind_in        = req_operation;
            open_in        = 1'b0;
            in_push        = 1'b1;
            in_res.status  = ST_UNKNOWN;
            in_res.last    = 1'b1;
         end else if (req_frame_start || open_ff) begin
            if (req_frame_start) begin
               kind_in   = req_operation;
               open_in   = 1'b1;
               pos_in    = '0;
               xor_in    = '0;
               cov_in    = COV_START;
               pcnt_in   = '0;
               acc_in    = '0;
               kindn_in  = '0;
               rcs_in    = '0;
               eflags_in = '0;
               hold_in   = '0;
            end
            p = pos_in;
            if (p == 5'd0) cmd_in = req_rx_byte;
            if (p == 5'd1) src_in = req_rx_byte;
            if (p == 5'd3) begin
               len_in = req_rx_byte;
               if (req_rx_byte == LEN_SPECIAL) begin
                  cov_in = (cmd_in[7:4] == CMD_ACK_NIBBLE) ? COV_SPECIAL_ACK : COV_SPECIAL;
               end else begin
                  cov_in = 5'(req_rx_byte[3:0]) + COV_START;
               end
            end
            if (p < cov_in) xor_in = xor_in ^ req_rx_byte;

            case (kind_in)
               KIND_READ:   total = 5'd7 + 5'(len_in[3:0]);
               KIND_ANALOG: total = 5'd12;
               default:     total = 5'd7;
            endcase
            tail_start = total - 5'd3;
            pos_in     = p + 5'd1;

            if (p >= 5'd4) begin
               if (p < tail_start) begin
                  off    = p - 5'd4;
                  off_m1 = off - 5'd1;
                  if (kind_in == KIND_READ) begin
                     if (!off[0]) begin
                        hold_in = req_rx_byte[3:0];
                     end else begin
                        store_req  = 1'b1;
                        store_data = {req_rx_byte[3:0], hold_in};
                     end
                  end else if (kind_in == KIND_ANALOG) begin
                     if (off == 5'd0) begin
                        kindn_in = req_rx_byte[3:0];
                     end else begin
                        if (req_rx_byte[7:4] != data_prefix_ff) eflags_in[FLAG_DATA] = 1'b1;
                        acc_in = acc_in | (16'(req_rx_byte[3:0]) << {off_m1[1:0], 2'b00});
                     end
                  end
               end else if (p == tail_start) begin
                  if (req_rx_byte[7:4] != checksum_prefix_ff) eflags_in[FLAG_TAIL] = 1'b1;
                  rcs_in[3:0] = req_rx_byte[3:0];
                  if ((kind_in == KIND_READ) && len_in[0]) begin
                     store_req  = 1'b1;
                     store_data = {req_rx_byte[3:0], hold_in};
                  end
               end else if (p == tail_start + 5'd1) begin
                  if (req_rx_byte[7:4] != checksum_prefix_ff) eflags_in[FLAG_TAIL] = 1'b1;
                  rcs_in[7:4] = req_rx_byte[3:0];
               end else begin
                  // end byte: close the frame and judge it
                  open_in  = 1'b0;
                  pos_in   = '0;
                  head_bad = len_in[7:4] != length_prefix_ff;
                  tail_bad = eflags_in[FLAG_TAIL] || (req_rx_byte != end_marker_ff);
                  cmd_bad  = cmd_in != ack_code_ff;
                  cov_bad  = cov_in > total;
                  crc_bad  = xor_in != rcs_in;
                  cap_bad  = pcnt_in > cap;
                  case (kind_in)
                     KIND_STATUS: begin
                        st_sel = head_bad ? ST_FRAMING : tail_bad ? ST_FRAMING :
                                 cmd_bad ? ST_DEVICE : cov_bad ? ST_FRAMING :
                                 crc_bad ? ST_CHECKSUM : ST_OK;
                        in_push        = 1'b1;
                        in_res.status  = st_sel;
                        in_res.channel = (st_sel == ST_OK) ? src_in[3:0] : 4'd0;
                        in_res.last    = 1'b1;
                     end
                     KIND_READ: begin
                        st_sel = head_bad ? ST_FRAMING : cmd_bad ? ST_DEVICE :
                                 cap_bad ? ST_CAPACITY : tail_bad ? ST_FRAMING :
                                 cov_bad ? ST_FRAMING : crc_bad ? ST_CHECKSUM : ST_OK;
                        if (st_sel == ST_OK) begin
                           drain_busy_in = 1'b1;
                           drain_idx_in  = '0;
                           drain_cnt_in  = (pcnt_in > MAX_CNT) ? MAX_CNT : pcnt_in;
                        end else begin
                           in_push       = 1'b1;
                           in_res.status = st_sel;
                           in_res.last   = 1'b1;
                        end
                     end
                     default: begin
                        st_sel = tail_bad ? ST_FRAMING : cmd_bad ? ST_DEVICE :
                                 cov_bad ? ST_FRAMING : crc_bad ? ST_CHECKSUM :
                                 eflags_in[FLAG_DATA] ? ST_FRAMING : ST_OK;
                        in_push       = 1'b1;
                        in_res.status = st_sel;
                        in_res.last   = 1'b1;
                        if (st_sel == ST_OK) begin
                           in_res.channel      = src_in[3:0];
                           in_res.signal_kind  = kindn_in;
                           in_res.sample_value = acc_in;
                        end
                     end
                  endcase
               end
            end

            if (store_req) begin
               if (pcnt_in < MAX_CNT) begin
                  mem_we    = 1'b1;
                  mem_waddr = pcnt_in[IDX_W-1:0];
                  mem_wdata = store_data;
               end
               if (pcnt_in != 4'hf) pcnt_in = pcnt_in + 4'd1;
            end
         end
      end

      // read-back sequencer: advance one entry a cycle while the queue has room, then queue the status
      rd_issue          = 1'b0;
      drain_status_push = 1'b0;
      if (drain_busy_ff) begin
         if (drain_idx_ff != drain_cnt_ff) begin
            if (occ_after <= 3'd1) begin
               rd_issue     = 1'b1;
               drain_idx_in = drain_idx_ff + 4'd1;
            end
         end else if (!rd_pending_ff && ((q_count_ff != 2'd2) || pop)) begin
            drain_status_push = 1'b1;
            drain_busy_in     = 1'b0;
         end
      end
   end

   always_comb begin
      occ_after = 3'(q_count_ff) + 3'(rd_pending_ff) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (mem_we) payload_mem[mem_waddr] <= mem_wdata;
      if (rd_issue) rd_data_ff <= payload_mem[drain_idx_ff[IDX_W-1:0]];
   end

   // result queue
   assign pop       = (q_count_ff != 2'd0) && !rsp_stall;
   assign rsp_valid = q_count_ff != 2'd0;

   always_comb begin
      push     = 1'b0;
      push_res = '0;
      if (rd_pending_ff) begin
         push               = 1'b1;
         push_res.status    = ST_OK;
         push_res.data_byte = rd_data_ff;
      end else if (drain_status_push) begin
         push            = 1'b1;
         push_res.status = ST_OK;
         push_res.last   = 1'b1;
      end else if (in_push) begin
         push     = 1'b1;
         push_res = in_res;
      end
      q_count_in = q_count_ff + 2'(push) - 2'(pop);
   end

   assign rsp_status       = q_ff[q_rd_ff].status;
   assign rsp_data_byte    = q_ff[q_rd_ff].data_byte;
   assign rsp_channel      = q_ff[q_rd_ff].channel;
   assign rsp_signal_kind  = q_ff[q_rd_ff].signal_kind;
   assign rsp_sample_value = q_ff[q_rd_ff].sample_value;
   assign rsp_last         = q_ff[q_rd_ff].last;

   always_ff @(posedge clock) begin
      if (push) q_ff[q_wr_ff] <= push_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         pos_ff        <= '0;
         kind_ff       <= '0;
         xor_ff        <= '0;
         cov_ff        <= '0;
         cmd_ff        <= '0;
         src_ff        <= '0;
         len_ff        <= '0;
         hold_ff       <= '0;
         pcnt_ff       <= '0;
         acc_ff        <= '0;
         kindn_ff      <= '0;
         rcs_ff        <= '0;
         eflags_ff     <= '0;
         drain_busy_ff <= 1'b0;
         drain_idx_ff  <= '0;
         drain_cnt_ff  <= '0;
         rd_pending_ff <= 1'b0;
         q_wr_ff       <= 1'b0;
         q_rd_ff       <= 1'b0;
         q_count_ff    <= '0;
      end else begin
         open_ff       <= open_in;
         pos_ff        <= pos_in;
         kind_ff       <= kind_in;
         xor_ff        <= xor_in;
         cov_ff        <= cov_in;
         cmd_ff        <= cmd_in;
         src_ff        <= src_in;
         len_ff        <= len_in;
         hold_ff       <= hold_in;
         pcnt_ff       <= pcnt_in;
         acc_ff        <= acc_in;
         kindn_ff      <= kindn_in;
         rcs_ff        <= rcs_in;
         eflags_ff     <= eflags_in;
         drain_busy_ff <= drain_busy_in;
         drain_idx_ff  <= drain_idx_in;
         drain_cnt_ff  <= drain_cnt_in;
         rd_pending_ff <= rd_issue;
         q_wr_ff       <= q_wr_ff ^ push;
         q_rd_ff       <= q_rd_ff ^ pop;
         q_count_ff    <= q_count_in;
      end
   end

   `NFRD_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_count_ff != 2'd3)
   `NFRD_ASSERT_IMP(a_read_has_room, clock, reset, rd_pending_ff, q_count_ff != 2'd2)
   `NFRD_ASSERT_IMP(a_drain_frame_closed, clock, reset, drain_busy_ff, !open_ff)
   `NFRD_ASSERT_IMP(a_drain_from_item, clock, reset, $rose(drain_busy_ff), $past(req_fire))

endmodule

// ----- verif/nfrd_reply_check.sv -----
`timescale 1ns / 1ps

module nfrd_reply_check
   import nfrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_data_byte,
   input  logic [3:0]  rsp_channel,
   input  logic [3:0]  rsp_signal_kind,
   input  logic [15:0] rsp_sample_value,
   input  logic        rsp_last,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,

   output int          failures,
   output int          outstanding,
   output int          results_checked
);

   localparam int HEAD_BYTES         = 4;
   localparam int TAIL_BYTES         = 3;
   localparam int STATUS_FRAME_BYTES = 7;
   localparam int ANALOG_FRAME_BYTES = 12;

   // settings as last written
   logic [7:0] want_ack;
   logic [3:0] want_len_pfx;
   logic [3:0] want_sum_pfx;
   logic [3:0] want_data_pfx;
   logic [7:0] want_end;
   logic [3:0] read_room;

   // decoder state
   logic        in_frame;
   logic [4:0]  pos;
   logic [1:0]  kind;
   logic [7:0]  xor_sum;
   logic [4:0]  cover_len;
   logic [7:0]  cmd_b;
   logic [7:0]  src_b;
   logic [7:0]  len_b;
   logic [3:0]  nib_hold;
   logic [7:0]  pay [NFRD_MAX_PAYLOAD];
   logic [3:0]  pay_cnt;
   logic [15:0] value_acc;
   logic [3:0]  sig_nib;
   logic [7:0]  rx_sum;
   logic [5:0]  flags;

   result_type pending_replies [$];

   function automatic void expect_reply(logic [2:0] st, logic [7:0] db, logic [3:0] ch,
                                        logic [3:0] sk, logic [15:0] sv, logic lst);
      result_type r;
      r.status       = st;
      r.data_byte    = db;
      r.channel      = ch;
      r.signal_kind  = sk;
      r.sample_value = sv;
      r.last         = lst;
      pending_replies.push_back(r);
   endfunction

   function automatic int frame_bytes();
      if (kind == KIND_READ) return STATUS_FRAME_BYTES + int'(len_b[3:0]);
      if (kind == KIND_ANALOG) return ANALOG_FRAME_BYTES;
      return STATUS_FRAME_BYTES;
   endfunction

   function automatic void keep_data_byte(logic [7:0] v);
      if (pay_cnt < NFRD_MAX_PAYLOAD) pay[pay_cnt] = v;
      if (pay_cnt < 4'd15) pay_cnt++;
   endfunction

   task automatic decode_rx_byte(logic [1:0] op, logic [7:0] b, logic starts);
      int p;
      int total;
      int tail_at;
      int o;
      int room;
      logic head_bad, tail_bad, cmd_bad, cover_bad, sum_bad;
      logic [2:0] st;
      if (starts) begin
         kind = op;
         if (op == KIND_UNKNOWN) begin
            in_frame = 1'b0;
            expect_reply(ST_UNKNOWN, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b1);
            return;
         end
         in_frame  = 1'b1;
         pos       = '0;
         xor_sum   = '0;
         cover_len = COV_START;
         pay_cnt   = '0;
         value_acc = '0;
         sig_nib   = '0;
         rx_sum    = '0;
         flags     = '0;
         nib_hold  = '0;
      end else if (!in_frame) begin
         return;
      end

      p = pos;
      if (p == 0) cmd_b = b;
      else if (p == 1) src_b = b;
      else if (p == 3) begin
         len_b = b;
         if (b == LEN_SPECIAL)
            cover_len = (cmd_b[7:4] == CMD_ACK_NIBBLE) ? COV_SPECIAL_ACK : COV_SPECIAL;
         else
            cover_len = 5'(b[3:0]) + COV_START;
      end
      if (p < cover_len) xor_sum ^= b;

      if (p >= HEAD_BYTES) begin
         total   = frame_bytes();
         tail_at = total - TAIL_BYTES;
         if (p < tail_at) begin
            o = p - HEAD_BYTES;
            if (kind == KIND_READ) begin
               // two nibble bytes per data byte, low nibble first
               if (o % 2 == 0) nib_hold = b[3:0];
               else keep_data_byte({b[3:0], nib_hold});
            end else if (kind == KIND_ANALOG) begin
               if (o == 0) sig_nib = b[3:0];
               else begin
                  if (b[7:4] != want_data_pfx) flags[FLAG_DATA] = 1'b1;
                  value_acc |= 16'(b[3:0]) << (4 * (o - 1));
               end
            end
         end else if (p == tail_at) begin
            if (b[7:4] != want_sum_pfx) flags[FLAG_TAIL] = 1'b1;
            rx_sum[3:0] = b[3:0];
            // odd payload: the last data byte borrows the checksum nibble
            if (kind == KIND_READ && len_b[0]) keep_data_byte({b[3:0], nib_hold});
         end else if (p == tail_at + 1) begin
            if (b[7:4] != want_sum_pfx) flags[FLAG_TAIL] = 1'b1;
            rx_sum[7:4] = b[3:0];
         end else begin
            in_frame  = 1'b0;
            pos       = '0;
            head_bad  = (len_b[7:4] != want_len_pfx);
            tail_bad  = flags[FLAG_TAIL] || (b != want_end);
            cmd_bad   = (cmd_b != want_ack);
            cover_bad = (cover_len > total);
            sum_bad   = (xor_sum != rx_sum);
            room      = (read_room > NFRD_MAX_PAYLOAD) ? NFRD_MAX_PAYLOAD : int'(read_room);
            if (kind == KIND_STATUS) begin
               st = (head_bad || tail_bad) ? ST_FRAMING : cmd_bad ? ST_DEVICE
                  : cover_bad ? ST_FRAMING : sum_bad ? ST_CHECKSUM : ST_OK;
               expect_reply(st, 8'h00, (st == ST_OK) ? src_b[3:0] : 4'h0, 4'h0, 16'h0000, 1'b1);
            end else if (kind == KIND_READ) begin
               st = head_bad ? ST_FRAMING : cmd_bad ? ST_DEVICE
                  : (pay_cnt > room) ? ST_CAPACITY : (tail_bad || cover_bad) ? ST_FRAMING
                  : sum_bad ? ST_CHECKSUM : ST_OK;
               if (st == ST_OK)
                  for (int i = 0; i < pay_cnt && i < NFRD_MAX_PAYLOAD; i++)
                     expect_reply(ST_OK, pay[i], 4'h0, 4'h0, 16'h0000, 1'b0);
               expect_reply(st, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b1);
            end else begin
               st = tail_bad ? ST_FRAMING : cmd_bad ? ST_DEVICE : cover_bad ? ST_FRAMING
                  : sum_bad ? ST_CHECKSUM : flags[FLAG_DATA] ? ST_FRAMING : ST_OK;
               if (st == ST_OK)
                  expect_reply(ST_OK, 8'h00, src_b[3:0], sig_nib, value_acc, 1'b1);
               else
                  expect_reply(st, 8'h00, 4'h0, 4'h0, 16'h0000, 1'b1);
            end
            return;
         end
      end
      pos = 5'(p + 1);
   endtask

   function automatic bit field_matches(string name, logic [15:0] want, logic [15:0] seen);
      if (seen === want) return 1'b1;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      bit ok;
      if (reset) begin
         pending_replies.delete();
         failures        = 0;
         results_checked = 0;
         want_ack        = RST_ACK_CODE;
         want_len_pfx    = RST_LENGTH_PREFIX;
         want_sum_pfx    = RST_CHECKSUM_PREFIX;
         want_data_pfx   = RST_DATA_PREFIX;
         want_end        = RST_END_MARKER;
         read_room       = RST_READ_CAPACITY;
         in_frame        = 1'b0;
         pos             = '0;
         kind            = '0;
         xor_sum         = '0;
         cover_len       = '0;
         cmd_b           = '0;
         src_b           = '0;
         len_b           = '0;
         nib_hold        = '0;
         pay_cnt         = '0;
         value_acc       = '0;
         sig_nib         = '0;
         rx_sum          = '0;
         flags           = '0;
      end else begin
         // results first, so an item accepted at this edge cannot cover for a stray result
         if (rsp_valid && !rsp_stall) begin
            seen.status       = rsp_status;
            seen.data_byte    = rsp_data_byte;
            seen.channel      = rsp_channel;
            seen.signal_kind  = rsp_signal_kind;
            seen.sample_value = rsp_sample_value;
            seen.last         = rsp_last;
            results_checked++;
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected result, expected none, got status %0d data %0h",
                        $time, seen.status, seen.data_byte);
               $display("   channel %0h kind %0h value %0h last %0b", seen.channel,
                        seen.signal_kind, seen.sample_value, seen.last);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               ok = 1'b1;
               ok = ok & field_matches("status", 16'(want.status), 16'(seen.status));
               ok = ok & field_matches("data_byte", 16'(want.data_byte), 16'(seen.data_byte));
               ok = ok & field_matches("channel", 16'(want.channel), 16'(seen.channel));
               ok = ok & field_matches("signal_kind", 16'(want.signal_kind),
                                       16'(seen.signal_kind));
               ok = ok & field_matches("sample_value", want.sample_value, seen.sample_value);
               ok = ok & field_matches("last", 16'(want.last), 16'(seen.last));
               if (!ok) failures++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACK_CODE:        want_ack      = csr_wdata;
               CSR_LENGTH_PREFIX:   want_len_pfx  = csr_wdata[3:0];
               CSR_CHECKSUM_PREFIX: want_sum_pfx  = csr_wdata[3:0];
               CSR_DATA_PREFIX:     want_data_pfx = csr_wdata[3:0];
               CSR_END_MARKER:      want_end      = csr_wdata;
               CSR_READ_CAPACITY:   read_room     = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            decode_rx_byte(req_operation, req_rx_byte, req_frame_start);
      end
      outstanding = pending_replies.size();
   end

endmodule

// ----- verif/nibble_frame_reply_decoder_test.sv -----
`timescale 1ns / 1ps

module nibble_frame_reply_decoder_test
   import nfrd_pkg::*;
();

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BYTES   = 36;

   typedef enum int {FAULT_NONE, FAULT_FLIP, FAULT_CUT, FAULT_NOISE,
                     FAULT_CMD, FAULT_END, FAULT_SUM, FAULT_LEN} fault_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        req_frame_start = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_data_byte;
   logic [3:0]  rsp_channel;
   logic [3:0]  rsp_signal_kind;
   logic [15:0] rsp_sample_value;
   logic        rsp_last;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int          failures;
   int          outstanding;
   int          results_checked;

   // settings as written, used only to build the frames sent
   logic [7:0]  cfg_ack = RST_ACK_CODE;
   logic [3:0]  cfg_len_pfx = RST_LENGTH_PREFIX;
   logic [3:0]  cfg_sum_pfx = RST_CHECKSUM_PREFIX;
   logic [3:0]  cfg_data_pfx = RST_DATA_PREFIX;
   logic [7:0]  cfg_end = RST_END_MARKER;

   bit          req_gaps = 1'b0;
   bit          rsp_gaps = 1'b0;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          settings_used = 1;

   nibble_frame_reply_decoder dut (.*);

   nfrd_reply_check watch (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_hold = rsp_gaps ? $urandom_range(0, 5) : 0;
         else if (rsp_hold > 0) rsp_hold--;
         else if (rsp_gaps && $urandom_range(0, 15) == 0) rsp_hold = $urandom_range(1, 5);
         rsp_stall <= (rsp_hold > 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_byte(logic [1:0] op, logic [7:0] b, logic starts);
      int gap;
      gap = req_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_rx_byte     <= b;
      req_frame_start <= starts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(logic [1:0] kind, int n, bit special, fill_type fill,
                             fault_type fault);
      logic [7:0] fb [$];
      logic [7:0] cmd;
      logic [7:0] len;
      logic [7:0] sum;
      int cover_bytes;
      int tail_at;
      int spot;
      frames_sent++;
      req_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps <= ($urandom_range(0, 3) != 0);
      cmd = (fault == FAULT_CMD) ? ~cfg_ack : cfg_ack;
      len = special ? LEN_SPECIAL : {cfg_len_pfx, (kind == KIND_ANALOG) ? 4'd5 : 4'(n)};
      if (fault == FAULT_LEN) len[7:4] = ~len[7:4];
      fb = '{cmd, 8'($urandom), 8'($urandom), len};
      if (kind == KIND_READ) begin
         repeat (len[3:0])
            fb.push_back(fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hff : 8'($urandom));
      end else if (kind == KIND_ANALOG) begin
         fb.push_back(8'($urandom));
         repeat (4)
            fb.push_back({cfg_data_pfx,
                          fill == FILL_ZERO ? 4'h0 : fill == FILL_ONES ? 4'hf : 4'($urandom)});
      end
      cover_bytes = (len == LEN_SPECIAL) ?
                    ((cmd[7:4] == CMD_ACK_NIBBLE) ? COV_SPECIAL_ACK : COV_SPECIAL) :
                    int'(len[3:0]) + COV_START;
      tail_at = fb.size();
      sum = '0;
      for (int i = 0; i < cover_bytes && i < tail_at; i++) sum ^= fb[i];
      if (fault == FAULT_SUM) sum ^= 8'(1) << $urandom_range(0, 7);
      fb.push_back({cfg_sum_pfx, sum[3:0]});
      fb.push_back({cfg_sum_pfx, sum[7:4]});
      fb.push_back((fault == FAULT_END) ? ~cfg_end : cfg_end);
      case (fault)
         FAULT_FLIP: begin
            spot = $urandom_range(0, fb.size() - 1);
            fb[spot] ^= 8'(1) << $urandom_range(0, 7);
         end
         // drop the tail: the next frame start restarts the decoder
         FAULT_CUT:   fb = fb[0 : $urandom_range(0, fb.size() - 2)];
         FAULT_NOISE: repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
         default: ;
      endcase
      foreach (fb[i]) send_byte((i == 0) ? kind : 2'($urandom), fb[i], i == 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_settings(logic [7:0] ack, logic [3:0] lp, logic [3:0] cp,
                                 logic [3:0] dp, logic [7:0] em, logic [3:0] cap);
      settle();
      write_register(CSR_ACK_CODE, ack);
      write_register(CSR_LENGTH_PREFIX, 8'(lp));
      write_register(CSR_CHECKSUM_PREFIX, 8'(cp));
      write_register(CSR_DATA_PREFIX, 8'(dp));
      write_register(CSR_END_MARKER, em);
      write_register(CSR_READ_CAPACITY, 8'(cap));
      csr_valid    <= 1'b0;
      cfg_ack      = ack;
      cfg_len_pfx  = lp;
      cfg_sum_pfx  = cp;
      cfg_data_pfx = dp;
      cfg_end      = em;
      settings_used++;
   endtask

   task automatic run_random(int budget);
      int stop_at;
      int r;
      int f;
      int n;
      logic [1:0] kind;
      fill_type fill;
      fault_type fault;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 4) send_byte(KIND_UNKNOWN, 8'($urandom), 1'b1);
         else if (r < 7) send_byte(2'($urandom), 8'($urandom), 1'b0);
         else begin
            kind = (r < 30) ? KIND_STATUS : (r < 70) ? KIND_READ : KIND_ANALOG;
            n = (kind == KIND_STATUS && $urandom_range(0, 7) != 0) ? 0 : $urandom_range(0, 15);
            f = $urandom_range(0, 7);
            fill = (f == 0) ? FILL_ZERO : (f == 1) ? FILL_ONES : FILL_RANDOM;
            fault = ($urandom_range(0, 9) < 6) ? FAULT_NONE : fault_type'($urandom_range(1, 7));
            send_frame(kind, n, $urandom_range(0, 3) == 0, fill, fault);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_frame(KIND_STATUS, 0, 1'b0, FILL_RANDOM, FAULT_NONE);
      send_frame(KIND_READ, 0, 1'b0, FILL_RANDOM, FAULT_NONE);
      send_frame(KIND_READ, 15, 1'b0, FILL_ONES, FAULT_NONE);
      send_frame(KIND_READ, 3, 1'b0, FILL_ZERO, FAULT_NONE);
      send_frame(KIND_ANALOG, 0, 1'b0, FILL_ZERO, FAULT_NONE);
      send_frame(KIND_ANALOG, 0, 1'b1, FILL_ONES, FAULT_NONE);
      send_byte(KIND_UNKNOWN, 8'hff, 1'b1);
      send_byte(KIND_UNKNOWN, 8'h00, 1'b0);
      send_byte(KIND_STATUS, 8'hff, 1'b0);
      send_frame(KIND_READ, 6, 1'b0, FILL_RANDOM, FAULT_CUT);
      send_frame(KIND_STATUS, 0, 1'b1, FILL_RANDOM, FAULT_NONE);
      send_frame(KIND_ANALOG, 0, 1'b0, FILL_RANDOM, FAULT_CUT);
      send_byte(KIND_UNKNOWN, 8'h5a, 1'b1);
      send_frame(KIND_STATUS, 5, 1'b0, FILL_RANDOM, FAULT_NONE);
      send_frame(KIND_STATUS, 0, 1'b0, FILL_RANDOM, FAULT_CMD);
      send_frame(KIND_READ, 4, 1'b0, FILL_RANDOM, FAULT_SUM);
      send_frame(KIND_ANALOG, 0, 1'b0, FILL_RANDOM, FAULT_END);
      send_frame(KIND_READ, 2, 1'b0, FILL_RANDOM, FAULT_LEN);
      send_frame(KIND_STATUS, 0, 1'b0, FILL_RANDOM, FAULT_NOISE);

      run_random(PHASE_BYTES);
      apply_settings(8'h00, 4'h0, 4'h0, 4'h0, 8'h00, 4'd0);
      run_random(PHASE_BYTES);
      apply_settings(8'hff, 4'hf, 4'hf, 4'hf, 8'hff, 4'd8);
      run_random(PHASE_BYTES);
      repeat (4) begin
         // keep the acknowledge high nibble and the usual length prefix often
         apply_settings({($urandom_range(0, 1) == 0) ? CMD_ACK_NIBBLE : 4'($urandom),
                         4'($urandom)},
                        ($urandom_range(0, 1) == 0) ? RST_LENGTH_PREFIX : 4'($urandom),
                        4'($urandom), 4'($urandom), 8'($urandom),
                        4'($urandom_range(0, 8)));
         run_random(PHASE_BYTES);
      end
      settle();

      $display("Sent %0d bytes in %0d frames under %0d register settings.",
               bytes_sent, frames_sent, settings_used);
      $display("Compared %0d results with the prediction, %0d mismatched.",
               results_checked, failures);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nfrd_pkg.sv
rtl/nibble_frame_reply_decoder.sv
verif/nfrd_reply_check.sv
verif/nibble_frame_reply_decoder_test.sv
